[rtl/core/ttcc_pkg.sv]
package ttcc_pkg;

	localparam int COORD_WIDTH_DEF = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 8;

	localparam logic [7:0] TAB_STEP   = 8'd4;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] CH_BEL     = 8'h07;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_HI   = 8'h7F;

	typedef enum logic {
		KIND_CHAR  = 1'b0,
		KIND_CLEAR = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEXT_ENABLE    = 3'd0,
		REG_SCREEN_WIDTH   = 3'd1,
		REG_SCREEN_HEIGHT  = 3'd2,
		REG_INSET_COLS     = 3'd3,
		REG_INSET_ROWS     = 3'd4,
		REG_CELL_ATTRIBUTE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic       text_enable;
		logic [7:0] screen_width;
		logic [7:0] screen_height;
		logic [6:0] inset_cols;
		logic [6:0] inset_rows;
		logic [7:0] cell_attribute;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_code;
	} item_t;

	typedef struct packed {
		logic       write_valid;
		logic [7:0] write_char;
		logic [7:0] write_col;
		logic [7:0] write_row;
		logic [7:0] write_attr;
		logic       beep;
		logic       scroll_request;
		logic       clear_request;
		logic [7:0] cursor_col;
		logic [7:0] cursor_row;
	} result_t;

endpackage

[rtl/core/ttcc_if.sv]
interface ttcc_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;

	modport source (output valid, kind, char_code, input ready);
	modport sink (input valid, kind, char_code, output ready);
endinterface

interface ttcc_out_if;
	logic       valid;
	logic       ready;
	logic       write_valid;
	logic [7:0] write_char;
	logic [7:0] write_col;
	logic [7:0] write_row;
	logic [7:0] write_attr;
	logic       beep;
	logic       scroll_request;
	logic       clear_request;
	logic [7:0] cursor_col;
	logic [7:0] cursor_row;

	modport source (output valid, write_valid, write_char, write_col, write_row, write_attr,
		beep, scroll_request, clear_request, cursor_col, cursor_row, input ready);
	modport sink (input valid, write_valid, write_char, write_col, write_row, write_attr,
		beep, scroll_request, clear_request, cursor_col, cursor_row, output ready);
endinterface

[rtl/core/ttcc_cfg.sv]
module ttcc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ttcc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ttcc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ttcc_pkg::cfg_t                      cfg
);

	ttcc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_enable    <= 1'b1;
			cfg_q.screen_width   <= 8'd80;
			cfg_q.screen_height  <= 8'd25;
			cfg_q.inset_cols     <= 7'd0;
			cfg_q.inset_rows     <= 7'd0;
			cfg_q.cell_attribute <= 8'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ttcc_pkg::REG_TEXT_ENABLE:    cfg_q.text_enable    <= cfg_data[0];
				ttcc_pkg::REG_SCREEN_WIDTH:   cfg_q.screen_width   <= cfg_data[7:0];
				ttcc_pkg::REG_SCREEN_HEIGHT:  cfg_q.screen_height  <= cfg_data[7:0];
				ttcc_pkg::REG_INSET_COLS:     cfg_q.inset_cols     <= cfg_data[6:0];
				ttcc_pkg::REG_INSET_ROWS:     cfg_q.inset_rows     <= cfg_data[6:0];
				ttcc_pkg::REG_CELL_ATTRIBUTE: cfg_q.cell_attribute <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/ttcc_step.sv]
module ttcc_step #(
	parameter int COORD_WIDTH = ttcc_pkg::COORD_WIDTH_DEF
) (
	input  ttcc_pkg::cfg_t           cfg,
	input  ttcc_pkg::item_t          item,
	input  logic [COORD_WIDTH-1:0]   col,
	input  logic [COORD_WIDTH-1:0]   row,
	output logic [COORD_WIDTH-1:0]   col_nxt,
	output logic [COORD_WIDTH-1:0]   row_nxt,
	output ttcc_pkg::result_t        res
);

	localparam int CW = COORD_WIDTH;
	localparam int EW = (CW > 8) ? CW : 8;

	logic [CW-1:0] col_a, row_a, col_b, row_b, row_c;
	logic [CW-1:0] ins_col_c;
	logic [EW-1:0] ins_ext;
	logic [CW-1:0] tab_step_c, tab_mask_c;
	logic          wrap, scroll;

	function automatic logic reached(input logic [CW-1:0] pos, input logic [7:0] size,
		input logic [6:0] inset);
		logic [7:0]    twice;
		logic [7:0]    lim;
		logic [EW-1:0] pos_e;
		twice = {inset, 1'b0};
		lim   = size - twice;
		pos_e = EW'(pos);
		return (twice <= size) && (pos_e >= EW'(lim));
	endfunction

	function automatic logic [7:0] low8(input logic [CW-1:0] v);
		logic [EW-1:0] e;
		e = EW'(v);
		return e[7:0];
	endfunction

	always_comb begin
		ins_ext    = EW'(cfg.inset_cols);
		ins_col_c  = ins_ext[CW-1:0];
		tab_step_c = CW'(ttcc_pkg::TAB_STEP);
		tab_mask_c = ~(tab_step_c - CW'(1));
	end

	always_comb begin
		res    = '0;
		col_a  = col;
		row_a  = row;
		col_b  = col;
		row_b  = row;
		row_c  = row;
		wrap   = 1'b0;
		scroll = 1'b0;

		if (item.char_code >= ttcc_pkg::PRINT_LO && item.char_code <= ttcc_pkg::PRINT_HI) begin
			res.write_valid = 1'b1;
			res.write_char  = item.char_code;
			res.write_col   = low8(col);
			res.write_row   = low8(row);
			res.write_attr  = cfg.cell_attribute;
			col_a           = col + CW'(1);
		end else if (item.char_code == ttcc_pkg::CH_TAB) begin
			col_a = (col + tab_step_c) & tab_mask_c;
		end else if (item.char_code == ttcc_pkg::CH_LF) begin
			row_a = row + CW'(1);
			col_a = ins_col_c;
		end else if (item.char_code == ttcc_pkg::CH_CR) begin
			col_a = ins_col_c;
		end else if (item.char_code == ttcc_pkg::CH_BEL) begin
			res.beep = 1'b1;
		end else if (item.char_code == ttcc_pkg::CH_BS) begin
			if (col != '0) begin
				col_a           = col - CW'(1);
				res.write_valid = 1'b1;
				res.write_char  = ttcc_pkg::SPACE_CHAR;
				res.write_col   = low8(col - CW'(1));
				res.write_row   = low8(row);
				res.write_attr  = cfg.cell_attribute;
			end
		end

		wrap  = reached(col_a, cfg.screen_width, cfg.inset_cols);
		col_b = wrap ? ins_col_c : col_a;
		row_b = wrap ? row_a + CW'(1) : row_a;

		scroll = reached(row_b, cfg.screen_height, cfg.inset_rows);
		row_c  = scroll ? row_b - CW'(1) : row_b;
		res.scroll_request = scroll;

		if (item.kind == ttcc_pkg::KIND_CLEAR) begin
			res               = '0;
			res.clear_request = 1'b1;
			col_nxt           = '0;
			row_nxt           = '0;
		end else if (!cfg.text_enable) begin
			res     = '0;
			col_nxt = col;
			row_nxt = row;
		end else begin
			col_nxt = col_b;
			row_nxt = row_c;
		end

		res.cursor_col = low8(col_nxt);
		res.cursor_row = low8(row_nxt);
	end

endmodule

[rtl/core/text_console_cursor_control.sv]
// Text console cursor control.
// in_ch (sink): one transaction per item, kind selects a character byte or a
// clear-and-home command; char_code carries the byte.
// out_ch (source): exactly one result transaction per input transaction, in
// order, carrying an optional cell write, beep, scroll and clear requests and
// the cursor position after the item.
// cfg_we/cfg_index/cfg_data: register writes, to be issued only while idle.
// A result passes through the input register, then the result register,
// before it is offered on out_ch. Throughput: one item per cycle while out_ch
// does not stall; the cursor update is a combinational loop through the
// column/row registers.
// Reset: cursor at 0,0, registers at their defaults, both stages empty.
// When out_ch stalls, the result register holds; one more item can be taken
// into the input register, then in_ch.ready drops until out_ch.ready returns.
module text_console_cursor_control #(
	parameter int COORD_WIDTH = ttcc_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ttcc_in_if.sink                         in_ch,
	ttcc_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [ttcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ttcc_pkg::CFG_DATA_W-1:0] cfg_data
);

	ttcc_pkg::cfg_t    cfg;
	ttcc_pkg::item_t   item_s1;
	ttcc_pkg::result_t res_comb, res_s2;
	logic              valid_s1, valid_s2;
	logic              adv_s1, in_acc;
	logic [COORD_WIDTH-1:0] col_q, row_q, col_nxt, row_nxt;

	ttcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ttcc_step #(.COORD_WIDTH(COORD_WIDTH)) u_step (
		.cfg     (cfg),
		.item    (item_s1),
		.col     (col_q),
		.row     (row_q),
		.col_nxt (col_nxt),
		.row_nxt (row_nxt),
		.res     (res_comb)
	);

	assign adv_s1      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (out_ch.ready)
				valid_s2 <= 1'b0;
			if (adv_s1) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.kind      <= in_ch.kind;
			item_s1.char_code <= in_ch.char_code;
		end
		if (adv_s1)
			res_s2 <= res_comb;
	end

	assign out_ch.valid          = valid_s2;
	assign out_ch.write_valid    = res_s2.write_valid;
	assign out_ch.write_char     = res_s2.write_char;
	assign out_ch.write_col      = res_s2.write_col;
	assign out_ch.write_row      = res_s2.write_row;
	assign out_ch.write_attr     = res_s2.write_attr;
	assign out_ch.beep           = res_s2.beep;
	assign out_ch.scroll_request = res_s2.scroll_request;
	assign out_ch.clear_request  = res_s2.clear_request;
	assign out_ch.cursor_col     = res_s2.cursor_col;
	assign out_ch.cursor_row     = res_s2.cursor_row;

	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(col_q) && $stable(row_q))
		else $error("cursor changed without an item");

	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.kind == ttcc_pkg::KIND_CLEAR |=> col_q == '0 && row_q == '0)
		else $error("clear did not home the cursor");

	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.clear_request |->
			!out_ch.write_valid && !out_ch.beep && !out_ch.scroll_request)
		else $error("clear result carries other requests");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ch.ready |=> valid_s2 && $stable(res_s2))
		else $error("stalled result lost");

endmodule

[bench/tb.sv]
module tb;
	import ttcc_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ttcc_in_if in_ch();
	ttcc_out_if out_ch();

	text_console_cursor_control dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cfg_t regs;
	logic [7:0] pos_col;
	logic [7:0] pos_row;
	result_t expected_updates[$];
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	logic hold_sink = 1'b0;

	function automatic logic at_limit(input logic [7:0] pos, input logic [7:0] size,
		input logic [6:0] inset);
		logic [8:0] twice;
		twice = {1'b0, inset, 1'b0};
		if (twice > {1'b0, size})
			return 1'b0;
		return {1'b0, pos} >= ({1'b0, size} - twice);
	endfunction

	function automatic result_t advance_cursor(input kind_t k, input logic [7:0] ch);
		result_t r;
		r = '0;
		if (k == KIND_CLEAR) begin
			pos_col = '0;
			pos_row = '0;
			r.clear_request = 1'b1;
		end else if (regs.text_enable) begin
			if (ch >= PRINT_LO && ch <= PRINT_HI) begin
				r.write_valid = 1'b1;
				r.write_char = ch;
				r.write_col = pos_col;
				r.write_row = pos_row;
				r.write_attr = regs.cell_attribute;
				pos_col = pos_col + 8'd1;
			end else if (ch == CH_TAB) begin
				pos_col = (pos_col + TAB_STEP) & ~(TAB_STEP - 8'd1);
			end else if (ch == CH_LF) begin
				pos_row = pos_row + 8'd1;
				pos_col = {1'b0, regs.inset_cols};
			end else if (ch == CH_CR) begin
				pos_col = {1'b0, regs.inset_cols};
			end else if (ch == CH_BEL) begin
				r.beep = 1'b1;
			end else if (ch == CH_BS) begin
				if (pos_col != 8'd0) begin
					pos_col = pos_col - 8'd1;
					r.write_valid = 1'b1;
					r.write_char = SPACE_CHAR;
					r.write_col = pos_col;
					r.write_row = pos_row;
					r.write_attr = regs.cell_attribute;
				end
			end
			if (at_limit(pos_col, regs.screen_width, regs.inset_cols)) begin
				pos_col = {1'b0, regs.inset_cols};
				pos_row = pos_row + 8'd1;
			end
			if (at_limit(pos_row, regs.screen_height, regs.inset_rows)) begin
				r.scroll_request = 1'b1;
				pos_row = pos_row - 8'd1;
			end
		end
		r.cursor_col = pos_col;
		r.cursor_row = pos_row;
		return r;
	endfunction

	task automatic send_item(input kind_t k, input logic [7:0] ch);
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.char_code <= ch;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		expected_updates.push_back(advance_cursor(k, ch));
	endtask

	// sender bursts with random gaps between them
	task automatic offer(input kind_t k, input logic [7:0] ch);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_item(k, ch);
	endtask

	task automatic offer_random();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 62)
			offer(KIND_CHAR, 8'($urandom_range(32, 127)));
		else if (pick < 70)
			offer(KIND_CHAR, CH_LF);
		else if (pick < 74)
			offer(KIND_CHAR, CH_CR);
		else if (pick < 78)
			offer(KIND_CHAR, CH_TAB);
		else if (pick < 84)
			offer(KIND_CHAR, CH_BS);
		else if (pick < 86)
			offer(KIND_CHAR, CH_BEL);
		else if (pick < 88)
			offer(KIND_CLEAR, 8'($urandom_range(0, 255)));
		else if (pick < 91)
			offer(kind_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		else
			offer(KIND_CHAR, 8'($urandom_range(0, 255)));
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (expected_updates.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic configure(input cfg_t c);
		settle();
		write_reg(REG_TEXT_ENABLE, {7'd0, c.text_enable});
		write_reg(REG_SCREEN_WIDTH, c.screen_width);
		write_reg(REG_SCREEN_HEIGHT, c.screen_height);
		write_reg(REG_INSET_COLS, {1'b0, c.inset_cols});
		write_reg(REG_INSET_ROWS, {1'b0, c.inset_rows});
		write_reg(REG_CELL_ATTRIBUTE, c.cell_attribute);
		cfg_we <= 1'b0;
		regs = c;
	endtask

	task automatic test_control_chars();
		configure(cfg_t'{1'b1, 8'd80, 8'd25, 7'd0, 7'd0, 8'd7});
		offer(KIND_CLEAR, 8'h00);
		offer(KIND_CHAR, 8'h41);
		offer(KIND_CHAR, PRINT_LO);
		offer(KIND_CHAR, PRINT_HI);
		repeat (4) offer(KIND_CHAR, CH_BS);	// last one lands at column 0
		offer(KIND_CHAR, CH_TAB);
		offer(KIND_CHAR, CH_TAB);
		offer(KIND_CHAR, 8'h78);
		offer(KIND_CHAR, CH_TAB);
		offer(KIND_CHAR, CH_CR);
		offer(KIND_CHAR, CH_LF);
		offer(KIND_CHAR, CH_BEL);
		offer(KIND_CHAR, 8'h00);
		offer(KIND_CHAR, 8'h01);
		offer(KIND_CHAR, 8'h1B);
		offer(KIND_CHAR, 8'h1F);
		offer(KIND_CHAR, 8'h80);
		offer(KIND_CHAR, 8'hFF);
		offer(KIND_CLEAR, 8'hFF);
	endtask

	task automatic test_screen_shapes();
		cfg_t shapes[$];
		cfg_t c;
		shapes = '{
			cfg_t'{1'b1, 8'd80, 8'd25, 7'd0, 7'd0, 8'd7},
			cfg_t'{1'b1, 8'd1, 8'd1, 7'd0, 7'd0, 8'h00},
			cfg_t'{1'b1, 8'd255, 8'd255, 7'd0, 7'd0, 8'hFF},
			cfg_t'{1'b1, 8'd255, 8'd255, 7'd127, 7'd127, 8'hA5},
			cfg_t'{1'b1, 8'd12, 8'd6, 7'd2, 7'd3, 8'h11},
			cfg_t'{1'b0, 8'd80, 8'd25, 7'd0, 7'd0, 8'd7},
			cfg_t'{1'b1, 8'd40, 8'd8, 7'd2, 7'd1, 8'h70},
			cfg_t'{1'b1, 8'd4, 8'd2, 7'd0, 7'd0, 8'hFF}
		};
		repeat (4) begin
			c.text_enable = ($urandom_range(0, 7) != 0);
			c.screen_width = 8'($urandom_range(1, 255));
			c.screen_height = 8'($urandom_range(1, 255));
			c.inset_cols = $urandom_range(0, 1) ? 7'($urandom_range(0, 127))
				: 7'($urandom_range(0, 3));
			c.inset_rows = $urandom_range(0, 1) ? 7'($urandom_range(0, 127))
				: 7'($urandom_range(0, 3));
			c.cell_attribute = 8'($urandom_range(0, 255));
			shapes.push_back(c);
		end
		foreach (shapes[i]) begin
			configure(shapes[i]);
			repeat (80) offer_random();
		end
	endtask

	// margins wider than the screen: nothing wraps, so the cursor rolls over
	task automatic test_coord_rollover();
		configure(cfg_t'{1'b1, 8'd20, 8'd10, 7'd127, 7'd127, 8'h3C});
		for (int i = 0; i < 70; i++) begin
			offer(KIND_CHAR, CH_TAB);
			if (i % 8 == 0)
				offer(KIND_CHAR, 8'($urandom_range(32, 127)));
		end
		repeat (260) offer(KIND_CHAR, CH_LF);
		offer(KIND_CLEAR, 8'h00);
	endtask

	task automatic test_backpressure();
		configure(cfg_t'{1'b1, 8'd16, 8'd4, 7'd1, 7'd0, 8'h1E});
		hold_sink = 1'b1;
		repeat (40) send_item(KIND_CHAR, 8'($urandom_range(32, 127)));
		settle();
		repeat (30) offer_random();
		settle();
	endtask

	// sink ready: random segments, plus one long hold on request
	initial begin : sink_ready
		int unsigned seg_left;
		int unsigned seg_mode;
		logic hold_done;
		seg_left = 0;
		seg_mode = 0;
		hold_done = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_sink && !hold_done) begin
				hold_done = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 64);
					seg_mode = $urandom_range(0, 2);
				end
				seg_left--;
				unique case (seg_mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					default: out_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got = {out_ch.write_valid, out_ch.write_char, out_ch.write_col, out_ch.write_row,
				out_ch.write_attr, out_ch.beep, out_ch.scroll_request, out_ch.clear_request,
				out_ch.cursor_col, out_ch.cursor_row};
			if (expected_updates.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transaction %h", $time, got);
			end else begin
				want = expected_updates.pop_front();
				compare_field("write_valid", 8'(want.write_valid), 8'(got.write_valid));
				compare_field("write_char", want.write_char, got.write_char);
				compare_field("write_col", want.write_col, got.write_col);
				compare_field("write_row", want.write_row, got.write_row);
				compare_field("write_attr", want.write_attr, got.write_attr);
				compare_field("beep", 8'(want.beep), 8'(got.beep));
				compare_field("scroll_request", 8'(want.scroll_request),
					8'(got.scroll_request));
				compare_field("clear_request", 8'(want.clear_request),
					8'(got.clear_request));
				compare_field("cursor_col", want.cursor_col, got.cursor_col);
				compare_field("cursor_row", want.cursor_row, got.cursor_row);
			end
		end
	end

	initial begin
		#2000000;
		$display("tb failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= 1'b0;
		in_ch.char_code <= '0;
		regs = cfg_t'{1'b1, 8'd80, 8'd25, 7'd0, 7'd0, 8'd7};
		pos_col = '0;
		pos_row = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_control_chars();
		test_screen_shapes();
		test_coord_rollover();
		test_backpressure();
		in_ch.valid <= 1'b0;
		for (int n = 0; n < 5000 && expected_updates.size() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_updates.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

[text_console_cursor_control.f]
rtl/core/ttcc_pkg.sv
rtl/core/ttcc_if.sv
rtl/core/ttcc_cfg.sv
rtl/core/ttcc_step.sv
rtl/core/text_console_cursor_control.sv
bench/tb.sv
